// ===== hw/rtl/point_in_polygon_test_macros.svh =====
// ----------------------------------------------------------------------------
// Point-in-polygon test: assertion macros
// Shared concurrent assertion wrappers; empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define PIP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true out of reset.
`define PIP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PIP_ASSERT(lbl, clk, rst_n, prop, msg)
`define PIP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test: package
// Field widths, defaults, action codes and the edge unit status word.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 16;

    localparam int VCOUNT_W = 7;
    localparam int VIDX_W   = 6;
    localparam int COUNT_W  = 7;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd3;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // edge unit status toward the sequencer
    typedef struct packed {
        logic busy;     // an edge is somewhere in the unit
        logic hit_vld;  // verdict for one edge this cycle
        logic hit;      // that edge crosses the ray
    } t_edge_stat;

endpackage

// ===== hw/rtl/pip_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test: command channel
// Valid/ready channel carrying one load or query word.
// ----------------------------------------------------------------------------
interface pip_cmd_if #(
    parameter int CoordBits = pip_pkg::COORD_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [pip_pkg::VIDX_W-1:0]     vertex_index;
    logic signed [CoordBits-1:0]    coord_x;
    logic signed [CoordBits-1:0]    coord_y;

    modport source (output valid, action, vertex_index, coord_x, coord_y, input ready);
    modport sink   (input valid, action, vertex_index, coord_x, coord_y, output ready);
endinterface

// ===== hw/rtl/pip_res_if.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test: result channel
// Valid/ready channel carrying one query verdict word.
// ----------------------------------------------------------------------------
interface pip_res_if;
    logic                           valid;
    logic                           ready;
    logic                           inside_res;
    logic [pip_pkg::COUNT_W-1:0]    crossing_count;

    modport source (output valid, inside_res, crossing_count, input ready);
    modport sink   (input valid, inside_res, crossing_count, output ready);
endinterface

// ===== hw/rtl/pip_ram.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pip_ram #(
    parameter int Width = 32,
    parameter int Depth = 64,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/pip_edge_unit.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test: edge unit
// Pipelined crossing test of one edge a cycle against the test point.
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_macros.svh"

module pip_edge_unit #(
    parameter int CoordBits = pip_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic signed [CoordBits-1:0] i_px,
    input  logic signed [CoordBits-1:0] i_py,
    input  logic signed [CoordBits-1:0] i_ax,
    input  logic signed [CoordBits-1:0] i_ay,
    input  logic signed [CoordBits-1:0] i_bx,
    input  logic signed [CoordBits-1:0] i_by,
    output pip_pkg::t_edge_stat         o_stat
);
    localparam int DW = CoordBits + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] w_dxp, w_dy, w_dxb, w_dyp;
    logic                 w_str, w_pos;

    logic                 r_s1_vld, r_s2_vld;
    logic signed [DW-1:0] r_dxp, r_dy, r_dxb, r_dyp;
    logic                 r_s1_str, r_s1_pos, r_s2_str, r_s2_pos;
    logic signed [PW-1:0] r_lhs, r_rhs;

    // differences fit one extra bit
    assign w_dxp = {i_px[CoordBits-1], i_px} - {i_ax[CoordBits-1], i_ax};
    assign w_dy  = {i_by[CoordBits-1], i_by} - {i_ay[CoordBits-1], i_ay};
    assign w_dxb = {i_bx[CoordBits-1], i_bx} - {i_ax[CoordBits-1], i_ax};
    assign w_dyp = {i_py[CoordBits-1], i_py} - {i_ay[CoordBits-1], i_ay};
    assign w_str = (i_ay > i_py) != (i_by > i_py);
    assign w_pos = i_by > i_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dxp    <= w_dxp;
        r_dy     <= w_dy;
        r_dxb    <= w_dxb;
        r_dyp    <= w_dyp;
        r_s1_str <= w_str;
        r_s1_pos <= w_pos;
        r_lhs    <= r_dxp * r_dy;
        r_rhs    <= r_dxb * r_dyp;
        r_s2_str <= r_s1_str;
        r_s2_pos <= r_s1_pos;
    end

    // compare direction follows the sign of dy
    assign o_stat.hit     = r_s2_str && (r_s2_pos ? (r_lhs < r_rhs) : (r_rhs < r_lhs));
    assign o_stat.hit_vld = r_s2_vld;
    assign o_stat.busy    = r_s1_vld | r_s2_vld;

    `PIP_ASSERT(a_hit_latency, i_clk, i_rst_n, r_s2_vld |-> $past(i_vld, 2), "edge verdict without an edge two cycles earlier")
    `PIP_ASSERT(a_s1_from_in, i_clk, i_rst_n, r_s1_vld |-> $past(i_vld), "stage one valid without input")
    `PIP_ASSERT(a_busy_cover, i_clk, i_rst_n, $past(i_vld) |-> o_stat.busy, "edge in flight not reported busy")
endmodule

// ===== hw/rtl/point_in_polygon_test.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test: top level
// Even-odd ray-casting test of a point against a stored polygon.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one word per handshake. A load word (action 0) writes
//   vertex_index's x/y into the vertex RAM and returns nothing;
//   slots at or beyond MAX_VERTICES are dropped. A query word (action 1)
//   tests coord_x/coord_y against the first n = min(vertex_count,
//   MAX_VERTICES) vertices and returns one word on o_res.
//   A query walks the vertex RAM one address a cycle and feeds one edge a
//   cycle into a two-stage edge unit. i_cmd is not ready during the walk
//   or while a finished query waits for the output register, and is
//   ready again in the same cycle that o_res.valid rises. Loads are
//   accepted back to back while idle.
//   i_cfg_we/i_cfg_wdata write vertex_count (reset value 3) while idle;
//   the user must keep to this, as the block itself does not enforce it.
//   Reset clears control state only; vertex RAM contents are undefined
//   until loaded. If o_res stalls, the result waits in the output register
//   and the next load or query is still accepted; a finished query holds
//   until the register frees.
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_macros.svh"

module point_in_polygon_test #(
    parameter int MaxVertices = pip_pkg::MAX_VERTICES_DEF,
    parameter int CoordBits   = pip_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pip_pkg::VCOUNT_W-1:0]    i_cfg_wdata,
    pip_cmd_if.sink                         i_cmd,
    pip_res_if.source                       o_res
);
    localparam int AW  = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
    localparam int VW  = pip_pkg::VCOUNT_W;
    localparam int CW  = pip_pkg::COUNT_W;
    localparam int IW  = pip_pkg::VIDX_W;
    localparam int RW  = 2 * CoordBits;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [VW-1:0]        r_vcount;
    logic [VW-1:0]        r_n, n_n;
    logic [VW-1:0]        r_rd_cnt, n_rd_cnt;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_rd_vld, r_rd_first, r_rd_last, r_wrap;
    logic                 r_out_vld, n_out_vld;
    logic                 r_out_inside;
    logic [CW-1:0]        r_out_count;
    logic signed [CoordBits-1:0] r_px, r_py;
    logic signed [CoordBits-1:0] r_prev_x, r_prev_y, r_first_x, r_first_y;

    logic                 w_acc, w_load, w_query, w_rd_en, w_out_free, w_finish;
    logic [VW-1:0]        w_qn;
    logic [AW+VW-1:0]     w_rd_ext;
    logic [AW+IW-1:0]     w_wr_ext;
    logic [RW-1:0]        w_rdata;
    logic signed [CoordBits-1:0] w_cur_x, w_cur_y, w_bx, w_by;
    logic                 w_e_vld;
    pip_pkg::t_edge_stat  w_stat;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_acc       = i_cmd.valid & i_cmd.ready;
    assign w_load      = w_acc && (i_cmd.action == pip_pkg::ACT_LOAD)
                         && (32'(i_cmd.vertex_index) < 32'(MaxVertices));
    assign w_query     = w_acc && (i_cmd.action == pip_pkg::ACT_QUERY);
    assign w_qn        = (32'(r_vcount) > 32'(MaxVertices)) ? VW'(MaxVertices) : r_vcount;
    assign w_rd_en     = (r_state == S_RUN) && (r_rd_cnt < r_n);
    assign w_rd_ext    = {{AW{1'b0}}, r_rd_cnt};
    assign w_wr_ext    = {{AW{1'b0}}, i_cmd.vertex_index};
    assign w_out_free  = !r_out_vld || o_res.ready;
    assign w_finish    = (r_rd_cnt == r_n) && !r_rd_vld && !r_wrap && !w_stat.busy;

    pip_ram #(
        .Width (RW),
        .Depth (MaxVertices)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (w_wr_ext[AW-1:0]),
        .i_wdata ({i_cmd.coord_x, i_cmd.coord_y}),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_ext[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_cur_x = $signed(w_rdata[RW-1:CoordBits]);
    assign w_cur_y = $signed(w_rdata[CoordBits-1:0]);

    // the closing edge pairs the last vertex with vertex zero
    assign w_e_vld = (r_rd_vld && !r_rd_first) || r_wrap;
    assign w_bx    = r_wrap ? r_first_x : w_cur_x;
    assign w_by    = r_wrap ? r_first_y : w_cur_y;

    pip_edge_unit #(
        .CoordBits (CoordBits)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_e_vld),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_ax    (r_prev_x),
        .i_ay    (r_prev_y),
        .i_bx    (w_bx),
        .i_by    (w_by),
        .o_stat  (w_stat)
    );

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_rd_cnt  = r_rd_cnt;
        n_count   = r_count;
        n_out_vld = r_out_vld;
        if (o_res.ready) begin
            n_out_vld = 1'b0;
        end
        if (w_stat.hit_vld && w_stat.hit) begin
            n_count = r_count + CW'(1);
        end
        case (r_state)
            S_IDLE: begin
                if (w_query) begin
                    n_state  = S_RUN;
                    n_n      = w_qn;
                    n_rd_cnt = '0;
                    n_count  = '0;
                end
            end
            S_RUN: begin
                if (w_rd_en) begin
                    n_rd_cnt = r_rd_cnt + VW'(1);
                end
                if (w_finish) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register frees
                if (w_out_free) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_vcount   <= pip_pkg::VCOUNT_RESET;
            r_n        <= '0;
            r_rd_cnt   <= '0;
            r_count    <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
            r_rd_last  <= 1'b0;
            r_wrap     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_n        <= n_n;
            r_rd_cnt   <= n_rd_cnt;
            r_count    <= n_count;
            r_rd_vld   <= w_rd_en;
            r_rd_first <= w_rd_en && (r_rd_cnt == '0);
            r_rd_last  <= w_rd_en && (r_rd_cnt == r_n - VW'(1));
            r_wrap     <= r_rd_vld && r_rd_last;
            r_out_vld  <= n_out_vld;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_px <= i_cmd.coord_x;
            r_py <= i_cmd.coord_y;
        end
        // advance the trailing vertex on every read word
        if (r_rd_vld) begin
            r_prev_x <= w_cur_x;
            r_prev_y <= w_cur_y;
            if (r_rd_first) begin
                r_first_x <= w_cur_x;
                r_first_y <= w_cur_y;
            end
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_inside <= r_count[0];
            r_out_count  <= r_count;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.inside_res     = r_out_inside;
    assign o_res.crossing_count = r_out_count;

    `PIP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= r_n, "crossing count exceeds edge count")
    `PIP_ASSERT(a_wrap_after_last, i_clk, i_rst_n, r_wrap |-> $past(r_rd_vld && r_rd_last), "closing edge without last vertex")
    `PIP_ASSERT(a_edge_in_run, i_clk, i_rst_n, w_stat.busy |-> r_state == S_RUN, "edge unit busy outside a query walk")
    `PIP_ASSERT(a_result_lands, i_clk, i_rst_n, (r_state == S_DONE && w_out_free) |=> (o_res.valid && r_state == S_IDLE), "finished query not presented")
    `PIP_ASSERT_NEVER(a_rd_beyond_n, i_clk, i_rst_n, r_rd_cnt > r_n, "vertex read counter past polygon size")
endmodule
